// ----- hw/rtl/hifb_pkg.sv -----
// shared types and codes for the half-duplex idle-framed bus controller
package hifb_pkg;

    localparam logic [2:0] ACT_RX_BYTE  = 3'd0;
    localparam logic [2:0] ACT_IDLE     = 3'd1;
    localparam logic [2:0] ACT_TX_EMPTY = 3'd2;
    localparam logic [2:0] ACT_SEND     = 3'd3;
    localparam logic [2:0] ACT_TIMER    = 3'd4;

    localparam logic [1:0] KIND_TX    = 2'd0;
    localparam logic [1:0] KIND_RX    = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    typedef struct packed {
        logic       rx_write;
        logic       frame_start;
        logic       rx_read;
        logic       tx_load_start;
        logic       tx_write;
        logic       tx_read;
        logic       out_load;
        logic [1:0] out_kind;
        logic       out_last;
    } cmd_t;

    typedef struct packed {
        logic rx_full;
        logic rx_empty;
        logic rx_more;
        logic tx_room;
        logic tx_more;
        logic out_free;
    } status_t;

endpackage

// ----- hw/rtl/hifb_ctrl.sv -----
// controller state machine: bus, send and timer flags, request sequencing
module hifb_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        action,
    input  logic              data_last,
    input  logic              cfg_wen,
    input  logic              cfg_wdata,
    input  hifb_pkg::status_t status,
    output hifb_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RX_RD,
        S_RX_OUT,
        S_EMPTY_OUT,
        S_TX_RD,
        S_TX_OUT
    } state_t;

    typedef enum logic [1:0] {
        LM_NONE,
        LM_LOAD,
        LM_DROP
    } lmode_t;

    state_t state_reg, state_next;
    lmode_t load_mode_reg, load_mode_next;
    lmode_t mode_eff;
    logic   bus_free_reg, bus_free_next;
    logic   tx_active_reg, tx_active_next;
    logic   tx_waiting_reg, tx_waiting_next;
    logic   timer_armed_reg, timer_armed_next;
    logic   ovf_reg, ovf_next;
    logic   use_timer_reg, use_timer_next;
    logic   send_after_reg, send_after_next;
    logic   accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        load_mode_next   = load_mode_reg;
        mode_eff         = load_mode_reg;
        bus_free_next    = bus_free_reg;
        tx_active_next   = tx_active_reg;
        tx_waiting_next  = tx_waiting_reg;
        timer_armed_next = timer_armed_reg;
        ovf_next         = ovf_reg;
        send_after_next  = send_after_reg;
        use_timer_next   = cfg_wen ? cfg_wdata : use_timer_reg;
        cmd              = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        hifb_pkg::ACT_RX_BYTE:
                        begin
                            bus_free_next = 1'b0;
                            if (!status.rx_full)
                            begin
                                cmd.rx_write = 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        hifb_pkg::ACT_IDLE:
                        begin
                            cmd.frame_start = 1'b1;
                            ovf_next        = 1'b0;
                            send_after_next = !use_timer_reg && tx_waiting_reg;
                            if (use_timer_reg)
                            begin
                                timer_armed_next = 1'b1;
                            end
                            else if (tx_waiting_reg)
                            begin
                                tx_active_next  = 1'b1;
                                tx_waiting_next = 1'b0;
                            end
                            else
                            begin
                                bus_free_next = 1'b1;
                            end
                            if (!ovf_reg)
                            begin
                                state_next = status.rx_empty ? S_EMPTY_OUT : S_RX_RD;
                            end
                            else if (!use_timer_reg && tx_waiting_reg)
                            begin
                                state_next = S_TX_RD;
                            end
                        end
                        hifb_pkg::ACT_TX_EMPTY:
                        begin
                            if (tx_active_reg)
                            begin
                                if (status.tx_more)
                                begin
                                    state_next = S_TX_RD;
                                end
                                else
                                begin
                                    tx_active_next = 1'b0;
                                    bus_free_next  = 1'b1;
                                end
                            end
                        end
                        hifb_pkg::ACT_SEND:
                        begin
                            if (load_mode_reg == LM_NONE)
                            begin
                                if (tx_active_reg || tx_waiting_reg)
                                begin
                                    mode_eff = LM_DROP;
                                end
                                else
                                begin
                                    mode_eff          = LM_LOAD;
                                    cmd.tx_load_start = 1'b1;
                                end
                            end
                            load_mode_next = mode_eff;
                            if (mode_eff == LM_LOAD)
                            begin
                                if (cmd.tx_load_start || status.tx_room)
                                begin
                                    cmd.tx_write = 1'b1;
                                end
                                if (data_last)
                                begin
                                    load_mode_next = LM_NONE;
                                    if (bus_free_reg)
                                    begin
                                        bus_free_next   = 1'b0;
                                        tx_active_next  = 1'b1;
                                        tx_waiting_next = 1'b0;
                                        state_next      = S_TX_RD;
                                    end
                                    else
                                    begin
                                        tx_waiting_next = 1'b1;
                                    end
                                end
                            end
                            else if (data_last)
                            begin
                                load_mode_next = LM_NONE;
                            end
                        end
                        hifb_pkg::ACT_TIMER:
                        begin
                            if (timer_armed_reg)
                            begin
                                timer_armed_next = 1'b0;
                                if (tx_waiting_reg)
                                begin
                                    tx_active_next  = 1'b1;
                                    tx_waiting_next = 1'b0;
                                    state_next      = S_TX_RD;
                                end
                                else
                                begin
                                    bus_free_next = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RX_RD:
            begin
                cmd.rx_read = 1'b1;
                state_next  = S_RX_OUT;
            end
            S_RX_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = hifb_pkg::KIND_RX;
                    cmd.out_last = !status.rx_more && !send_after_reg;
                    if (status.rx_more)
                    begin
                        state_next = S_RX_RD;
                    end
                    else
                    begin
                        state_next = send_after_reg ? S_TX_RD : S_IDLE;
                    end
                end
            end
            S_EMPTY_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = hifb_pkg::KIND_EMPTY;
                    cmd.out_last = !send_after_reg;
                    state_next   = send_after_reg ? S_TX_RD : S_IDLE;
                end
            end
            S_TX_RD:
            begin
                cmd.tx_read = 1'b1;
                state_next  = S_TX_OUT;
            end
            S_TX_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = hifb_pkg::KIND_TX;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            load_mode_reg   <= LM_NONE;
            bus_free_reg    <= 1'b1;
            tx_active_reg   <= 1'b0;
            tx_waiting_reg  <= 1'b0;
            timer_armed_reg <= 1'b0;
            ovf_reg         <= 1'b0;
            use_timer_reg   <= 1'b0;
            send_after_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            load_mode_reg   <= load_mode_next;
            bus_free_reg    <= bus_free_next;
            tx_active_reg   <= tx_active_next;
            tx_waiting_reg  <= tx_waiting_next;
            timer_armed_reg <= timer_armed_next;
            ovf_reg         <= ovf_next;
            use_timer_reg   <= use_timer_next;
            send_after_reg  <= send_after_next;
        end
    end

    a_send_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(tx_active_reg && tx_waiting_reg))
        else $error("send both active and waiting");

    a_timer_arm: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(timer_armed_reg) |->
            $past(accept && (action == hifb_pkg::ACT_IDLE) && use_timer_reg))
        else $error("timer armed without line idle in timer mode");

    a_wait_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(tx_waiting_reg) |-> $past(accept && (action == hifb_pkg::ACT_SEND)))
        else $error("send waiting without a send request");

    a_tx_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TX_OUT) && status.out_free |=> (state_reg == S_IDLE))
        else $error("transmit byte not the final result");

endmodule

// ----- hw/rtl/hifb_dp.sv -----
// datapath: receive slot and send memories, counters and output register
module hifb_dp #(
    parameter int SLOT_BYTES = 32,
    parameter int SLOT_COUNT = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        data_byte,
    input  hifb_pkg::cmd_t    cmd,
    output hifb_pkg::status_t status,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        kind,
    output logic [7:0]        out_byte,
    output logic [5:0]        frame_length,
    output logic [1:0]        slot_index,
    output logic              run_last
);

    localparam int FILL_W  = $clog2(SLOT_BYTES + 1);
    localparam int TXA_W   = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
    localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int RX_DEPTH = SLOT_BYTES * SLOT_COUNT;
    localparam int RXA_W   = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;

    logic [7:0] rx_mem [RX_DEPTH];
    logic [7:0] tx_mem [SLOT_BYTES];

    logic [FILL_W-1:0] rx_fill_reg, rx_fill_next;
    logic [SLOT_W-1:0] rx_ptr_reg, rx_ptr_next;
    logic [SLOT_W-1:0] dl_slot_reg, dl_slot_next;
    logic [FILL_W-1:0] dl_len_reg, dl_len_next;
    logic [FILL_W-1:0] rd_idx_reg, rd_idx_next;
    logic [FILL_W-1:0] tx_count_reg, tx_count_next;
    logic [FILL_W-1:0] tx_pos_reg, tx_pos_next;
    logic [FILL_W-1:0] tx_base;
    logic [7:0]        rx_rdata_reg;
    logic [7:0]        tx_rdata_reg;
    logic [RXA_W-1:0]  rx_waddr;
    logic [RXA_W-1:0]  rx_raddr;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        kind_reg;
    logic [7:0]        byte_reg;
    logic [5:0]        len_reg;
    logic [1:0]        slot_reg;
    logic              last_reg;
    logic [FILL_W+5:0] len_wide;
    logic [SLOT_W+1:0] slot_wide;

    assign rx_waddr = RXA_W'(int'(rx_ptr_reg) * SLOT_BYTES + int'(rx_fill_reg));
    assign rx_raddr = RXA_W'(int'(dl_slot_reg) * SLOT_BYTES + int'(rd_idx_reg));
    assign tx_base  = cmd.tx_load_start ? '0 : tx_count_reg;

    assign status.rx_full  = (rx_fill_reg == FILL_W'(SLOT_BYTES));
    assign status.rx_empty = (rx_fill_reg == '0);
    assign status.rx_more  = (rd_idx_reg < dl_len_reg);
    assign status.tx_room  = (tx_count_reg < FILL_W'(SLOT_BYTES));
    assign status.tx_more  = (tx_pos_reg < tx_count_reg);
    assign status.out_free = !out_valid_reg || !out_stall;

    assign len_wide  = {6'b0, dl_len_reg};
    assign slot_wide = {2'b0, dl_slot_reg};

    always_comb
    begin
        rx_fill_next  = rx_fill_reg;
        rx_ptr_next   = rx_ptr_reg;
        dl_slot_next  = dl_slot_reg;
        dl_len_next   = dl_len_reg;
        rd_idx_next   = rd_idx_reg;
        tx_count_next = tx_count_reg;
        tx_pos_next   = tx_pos_reg;
        if (cmd.rx_write)
        begin
            rx_fill_next = rx_fill_reg + 1'b1;
        end
        if (cmd.frame_start)
        begin
            dl_slot_next = rx_ptr_reg;
            dl_len_next  = rx_fill_reg;
            rd_idx_next  = '0;
            rx_fill_next = '0;
            rx_ptr_next  = (rx_ptr_reg == SLOT_W'(SLOT_COUNT - 1)) ? '0 : rx_ptr_reg + 1'b1;
        end
        if (cmd.rx_read)
        begin
            rd_idx_next = rd_idx_reg + 1'b1;
        end
        if (cmd.tx_load_start)
        begin
            tx_count_next = '0;
            tx_pos_next   = '0;
        end
        if (cmd.tx_write)
        begin
            tx_count_next = tx_base + 1'b1;
        end
        if (cmd.tx_read)
        begin
            tx_pos_next = tx_pos_reg + 1'b1;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // memories and read data
    always_ff @(posedge clk)
    begin
        if (cmd.rx_write)
        begin
            rx_mem[rx_waddr] <= data_byte;
        end
        if (cmd.rx_read)
        begin
            rx_rdata_reg <= rx_mem[rx_raddr];
        end
        if (cmd.tx_write)
        begin
            tx_mem[tx_base[TXA_W-1:0]] <= data_byte;
        end
        if (cmd.tx_read)
        begin
            tx_rdata_reg <= tx_mem[tx_pos_reg[TXA_W-1:0]];
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            kind_reg <= cmd.out_kind;
            last_reg <= cmd.out_last;
            case (cmd.out_kind)
                hifb_pkg::KIND_RX:
                begin
                    byte_reg <= rx_rdata_reg;
                    len_reg  <= len_wide[5:0];
                    slot_reg <= slot_wide[1:0];
                end
                hifb_pkg::KIND_EMPTY:
                begin
                    byte_reg <= 8'd0;
                    len_reg  <= 6'd0;
                    slot_reg <= slot_wide[1:0];
                end
                default:
                begin
                    byte_reg <= tx_rdata_reg;
                    len_reg  <= 6'd0;
                    slot_reg <= 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_fill_reg   <= '0;
            rx_ptr_reg    <= '0;
            dl_slot_reg   <= '0;
            dl_len_reg    <= '0;
            rd_idx_reg    <= '0;
            tx_count_reg  <= '0;
            tx_pos_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rx_fill_reg   <= rx_fill_next;
            rx_ptr_reg    <= rx_ptr_next;
            dl_slot_reg   <= dl_slot_next;
            dl_len_reg    <= dl_len_next;
            rd_idx_reg    <= rd_idx_next;
            tx_count_reg  <= tx_count_next;
            tx_pos_reg    <= tx_pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign out_byte     = byte_reg;
    assign frame_length = len_reg;
    assign slot_index   = slot_reg;
    assign run_last     = last_reg;

endmodule

// ----- hw/rtl/halfduplex_idle_framed_bus_ctrl_top.sv -----
// top level of the half-duplex idle-framed bus controller
// a request with no result is taken without stalling; input stalls until its last result is queued
// a sent byte is read from send memory (S_TX_RD) then loaded to the output register (S_TX_OUT)
// frame bytes alternate a registered slot memory read (S_RX_RD) and an output load (S_RX_OUT)
// so an idle request with a full slot holds the input until all its bytes are queued
// async active-low reset clears flags and counters; slot and send memories are not cleared
module halfduplex_idle_framed_bus_ctrl_top #(
    parameter int SLOT_BYTES = 32,
    parameter int SLOT_COUNT = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] action,
    input  logic [7:0] data_byte,
    input  logic       data_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] out_byte,
    output logic [5:0] frame_length,
    output logic [1:0] slot_index,
    output logic       run_last,
    input  logic       cfg_wen,
    input  logic       cfg_wdata
);

    hifb_pkg::cmd_t    cmd;
    hifb_pkg::status_t status;

    hifb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .data_last (data_last),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .status    (status),
        .cmd       (cmd)
    );

    hifb_dp #(
        .SLOT_BYTES (SLOT_BYTES),
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_byte    (data_byte),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .out_byte     (out_byte),
        .frame_length (frame_length),
        .slot_index   (slot_index),
        .run_last     (run_last)
    );

endmodule

// ----- test/halfduplex_idle_framed_bus_ctrl_top_tb.sv -----
// self-checking testbench for the half-duplex idle-framed bus controller top level
module halfduplex_idle_framed_bus_ctrl_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_BYTES = 32;
    localparam int SLOT_COUNT = 4;

    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] data;
        logic       last;
    } bus_req_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [5:0] length;
        logic [1:0] slot;
        logic       last;
    } bus_out_t;

    typedef enum logic [1:0] {
        LOAD_IDLE,
        LOAD_TAKE,
        LOAD_DROP
    } load_state_t;

    typedef enum logic [1:0] {
        BY_MODEL,
        NO_RESULT,
        ONE_RESULT
    } row_check_t;

    typedef struct {
        bus_req_t   req;
        row_check_t check;
        bus_out_t   res;
    } dir_row_t;

    localparam bus_out_t NO_OUT = '0;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [2:0] action = hifb_pkg::ACT_RX_BYTE;
    logic [7:0] data_byte = 8'h00;
    logic       data_last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [5:0] frame_length;
    logic [1:0] slot_index;
    logic       run_last;
    logic       cfg_wen = 1'b0;
    logic       cfg_wdata = 1'b0;

    // predicted controller state
    logic [7:0]  mem_rx [SLOT_COUNT*SLOT_BYTES];
    logic [7:0]  mem_tx [SLOT_BYTES];
    int          slot_ptr = 0;
    int          slot_fill = 0;
    bit          slot_over = 1'b0;
    int          tx_rd = 0;
    int          tx_len = 0;
    bit          line_free = 1'b1;
    bit          sending = 1'b0;
    bit          send_pending = 1'b0;
    load_state_t loader = LOAD_IDLE;
    bit          timer_on = 1'b0;
    bit          timer_mode = 1'b0;

    bus_out_t step_out [$];
    bus_out_t bus_out_q [$];

    int errors = 0;
    int items_sent = 0;
    bit in_nogap = 1'b0;
    bit out_nogap = 1'b0;
    bit long_hold = 1'b0;

    dir_row_t dir_table [21] = '{
        '{'{hifb_pkg::ACT_IDLE,     8'h00, 1'b0}, ONE_RESULT,
          '{hifb_pkg::KIND_EMPTY, 8'h00, 6'd0, 2'd0, 1'b1}},
        '{'{ACT_SPARE_LO,           8'hFF, 1'b1}, NO_RESULT,  NO_OUT},
        '{'{ACT_SPARE_HI,           8'h00, 1'b0}, NO_RESULT,  NO_OUT},
        '{'{hifb_pkg::ACT_TX_EMPTY, 8'h00, 1'b0}, NO_RESULT,  NO_OUT},
        '{'{hifb_pkg::ACT_TIMER,    8'h00, 1'b0}, NO_RESULT,  NO_OUT},
        '{'{hifb_pkg::ACT_SEND,     8'hFF, 1'b1}, ONE_RESULT,
          '{hifb_pkg::KIND_TX, 8'hFF, 6'd0, 2'd0, 1'b1}},
        '{'{hifb_pkg::ACT_SEND,     8'h00, 1'b1}, NO_RESULT,  NO_OUT},
        '{'{hifb_pkg::ACT_TX_EMPTY, 8'h00, 1'b0}, NO_RESULT,  NO_OUT},
        '{'{hifb_pkg::ACT_RX_BYTE,  8'h00, 1'b0}, NO_RESULT,  NO_OUT},
        '{'{hifb_pkg::ACT_RX_BYTE,  8'hFF, 1'b1}, NO_RESULT,  NO_OUT},
        '{'{hifb_pkg::ACT_SEND,     8'hA5, 1'b0}, NO_RESULT,  NO_OUT},
        '{'{hifb_pkg::ACT_SEND,     8'h5A, 1'b1}, NO_RESULT,  NO_OUT},
        '{'{hifb_pkg::ACT_SEND,     8'h11, 1'b0}, NO_RESULT,  NO_OUT},
        '{'{hifb_pkg::ACT_SEND,     8'h22, 1'b1}, NO_RESULT,  NO_OUT},
        '{'{hifb_pkg::ACT_IDLE,     8'h00, 1'b0}, BY_MODEL,   NO_OUT},
        '{'{hifb_pkg::ACT_TX_EMPTY, 8'h00, 1'b0}, BY_MODEL,   NO_OUT},
        '{'{hifb_pkg::ACT_TX_EMPTY, 8'h00, 1'b0}, NO_RESULT,  NO_OUT},
        '{'{hifb_pkg::ACT_IDLE,     8'h00, 1'b0}, ONE_RESULT,
          '{hifb_pkg::KIND_EMPTY, 8'h00, 6'd0, 2'd2, 1'b1}},
        '{'{hifb_pkg::ACT_RX_BYTE,  8'h80, 1'b0}, NO_RESULT,  NO_OUT},
        '{'{hifb_pkg::ACT_IDLE,     8'h00, 1'b0}, BY_MODEL,   NO_OUT},
        '{'{hifb_pkg::ACT_IDLE,     8'h00, 1'b0}, ONE_RESULT,
          '{hifb_pkg::KIND_EMPTY, 8'h00, 6'd0, 2'd0, 1'b1}}
    };

    halfduplex_idle_framed_bus_ctrl_top #(
        .SLOT_BYTES (SLOT_BYTES),
        .SLOT_COUNT (SLOT_COUNT)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .data_byte    (data_byte),
        .data_last    (data_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .out_byte     (out_byte),
        .frame_length (frame_length),
        .slot_index   (slot_index),
        .run_last     (run_last),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata)
    );

    always #6 clk = ~clk;

    function automatic void push_out(logic [1:0] k, logic [7:0] d, logic [5:0] l,
                                     logic [1:0] s);
        step_out.push_back('{k, d, l, s, 1'b0});
    endfunction

    function automatic void begin_send();
        int i;
        i = tx_rd;
        if (i >= SLOT_BYTES)
        begin
            i = 0;
        end
        push_out(hifb_pkg::KIND_TX, mem_tx[i], 6'd0, 2'd0);
        tx_rd = i + 1;
        sending = 1'b1;
        send_pending = 1'b0;
    endfunction

    function automatic void bus_step(bus_req_t r);
        int  len;
        int  slot;
        bit  over;
        int  i;
        step_out.delete();
        case (r.action)
            hifb_pkg::ACT_RX_BYTE:
            begin
                line_free = 1'b0;
                if (slot_fill < SLOT_BYTES)
                begin
                    mem_rx[slot_ptr*SLOT_BYTES + slot_fill] = r.data;
                    slot_fill++;
                end
                else
                begin
                    slot_over = 1'b1;
                end
            end
            hifb_pkg::ACT_IDLE:
            begin
                slot = slot_ptr;
                len = slot_fill;
                over = slot_over;
                slot_ptr = (slot_ptr + 1) % SLOT_COUNT;
                slot_fill = 0;
                slot_over = 1'b0;
                if (!over)
                begin
                    if (len == 0)
                    begin
                        push_out(hifb_pkg::KIND_EMPTY, 8'h00, 6'd0, slot[1:0]);
                    end
                    else
                    begin
                        for (i = 0; i < len; i++)
                        begin
                            push_out(hifb_pkg::KIND_RX, mem_rx[slot*SLOT_BYTES + i],
                                     len[5:0], slot[1:0]);
                        end
                    end
                end
                if (timer_mode)
                begin
                    timer_on = 1'b1;
                end
                else if (send_pending)
                begin
                    begin_send();
                end
                else
                begin
                    line_free = 1'b1;
                end
            end
            hifb_pkg::ACT_TX_EMPTY:
            begin
                if (sending)
                begin
                    if (tx_rd < tx_len && tx_rd < SLOT_BYTES)
                    begin
                        push_out(hifb_pkg::KIND_TX, mem_tx[tx_rd], 6'd0, 2'd0);
                        tx_rd++;
                    end
                    else
                    begin
                        sending = 1'b0;
                        line_free = 1'b1;
                    end
                end
            end
            hifb_pkg::ACT_SEND:
            begin
                if (loader == LOAD_IDLE)
                begin
                    if (sending || send_pending)
                    begin
                        loader = LOAD_DROP;
                    end
                    else
                    begin
                        loader = LOAD_TAKE;
                        tx_len = 0;
                        tx_rd = 0;
                    end
                end
                if (loader == LOAD_TAKE)
                begin
                    if (tx_len < SLOT_BYTES)
                    begin
                        mem_tx[tx_len] = r.data;
                        tx_len++;
                    end
                    if (r.last)
                    begin
                        loader = LOAD_IDLE;
                        tx_rd = 0;
                        if (line_free)
                        begin
                            line_free = 1'b0;
                            begin_send();
                        end
                        else
                        begin
                            send_pending = 1'b1;
                        end
                    end
                end
                else if (r.last)
                begin
                    loader = LOAD_IDLE;
                end
            end
            hifb_pkg::ACT_TIMER:
            begin
                if (timer_on)
                begin
                    timer_on = 1'b0;
                    if (send_pending)
                    begin
                        begin_send();
                    end
                    else
                    begin
                        line_free = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (step_out.size() > 0)
        begin
            step_out[step_out.size()-1].last = 1'b1;
        end
    endfunction

    task automatic offer(bus_req_t r, row_check_t chk = BY_MODEL, bus_out_t typed = NO_OUT);
        int gap;
        gap = in_nogap ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        bus_step(r);
        if (chk == BY_MODEL)
        begin
            foreach (step_out[i])
            begin
                bus_out_q.push_back(step_out[i]);
            end
        end
        else if (chk == ONE_RESULT)
        begin
            bus_out_q.push_back(typed);
        end
        in_valid  <= 1'b1;
        action    <= r.action;
        data_byte <= r.data;
        data_last <= r.last;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        @(negedge clk);
        if (r.action <= hifb_pkg::ACT_TIMER)
        begin
            items_sent++;
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        wait (bus_out_q.size() == 0);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_timer_mode(bit v);
        settle();
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_wen <= 1'b0;
        timer_mode = v;
    endtask

    function automatic int pick_len(int lo);
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom_range(SLOT_BYTES - 4, SLOT_BYTES + 4);
        end
        return $urandom_range(lo, 6);
    endfunction

    task automatic rx_frame(int n);
        repeat (n) offer('{hifb_pkg::ACT_RX_BYTE, 8'($urandom), 1'($urandom)});
        offer('{hifb_pkg::ACT_IDLE, 8'($urandom), 1'($urandom)});
    endtask

    task automatic tx_message(int n);
        int i;
        for (i = 0; i < n; i++)
        begin
            offer('{hifb_pkg::ACT_SEND, 8'($urandom), (i == n - 1)});
        end
    endtask

    task automatic run_phase(int n);
        int start;
        int pick;
        start = items_sent;
        while (items_sent - start < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                rx_frame(pick_len(0));
            end
            else if (pick < 55)
            begin
                tx_message(pick_len(1));
            end
            else if (pick < 75)
            begin
                repeat ($urandom_range(1, 4))
                    offer('{hifb_pkg::ACT_TX_EMPTY, 8'($urandom), 1'($urandom)});
            end
            else if (pick < 85)
            begin
                offer('{hifb_pkg::ACT_TIMER, 8'($urandom), 1'($urandom)});
            end
            else if (pick < 92)
            begin
                offer('{hifb_pkg::ACT_IDLE, 8'($urandom), 1'($urandom)});
            end
            else if (pick < 94)
            begin
                settle();
            end
            else
            begin
                offer('{3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom)});
            end
        end
    endtask

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        bus_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (bus_out_q.size() == 0)
            begin
                $error("unexpected result: kind %0d, out_byte %0d", kind, out_byte);
                errors++;
            end
            else
            begin
                want = bus_out_q.pop_front();
                check_field("kind", 8'(want.kind), 8'(kind));
                check_field("out_byte", want.data, out_byte);
                check_field("frame_length", 8'(want.length), 8'(frame_length));
                check_field("slot_index", 8'(want.slot), 8'(slot_index));
                check_field("run_last", 8'(want.last), 8'(run_last));
            end
        end
    end

    initial
    begin : receiver
        int hold;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (long_hold)
            begin
                hold = 400;
                long_hold = 1'b0;
            end
            else
            begin
                hold = out_nogap ? 0 : $urandom_range(0, 10);
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (!out_valid);
            @(negedge clk);
        end
    end

    initial
    begin : watchdog
        #30ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        int p;
        int spin;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_table[i])
        begin
            offer(dir_table[i].req, dir_table[i].check, dir_table[i].res);
        end

        // overflowing frame, full frame, oversized message drained by transmit-empty events
        rx_frame(SLOT_BYTES + 1);
        rx_frame(SLOT_BYTES);
        tx_message(SLOT_BYTES + 2);
        repeat (SLOT_BYTES + 1)
            offer('{hifb_pkg::ACT_TX_EMPTY, 8'($urandom), 1'($urandom)});
        run_phase(20);

        for (p = 1; p <= 5; p++)
        begin
            write_timer_mode(p[0]);
            in_nogap  = (p == 3) || ($urandom_range(0, 4) == 0);
            out_nogap = (p == 3) || ($urandom_range(0, 4) == 0);
            if (p == 2)
            begin
                // receiver holds off while full and partial frames keep coming
                long_hold = 1'b1;
                rx_frame(SLOT_BYTES);
                rx_frame(12);
                rx_frame(SLOT_BYTES);
            end
            run_phase(30);
        end

        in_valid <= 1'b0;
        spin = 0;
        while (bus_out_q.size() != 0 && spin < 200000)
        begin
            @(posedge clk);
            spin++;
        end
        if (bus_out_q.size() != 0)
        begin
            $error("%0d expected results never arrived", bus_out_q.size());
            errors++;
        end
        repeat (80) @(posedge clk);
        if (errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
